>>> rtl/core/ptrs_pkg.sv
// ptrs_pkg: shared types and codes for the periodic task release scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ptrs_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_STARTED  = 3'd3,
    KIND_STOPPED  = 3'd4,
    KIND_NOT_DUE  = 3'd5,
    KIND_DISPATCH = 3'd6,
    KIND_CYC_END  = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_MOD,
    ST_SCAN_WR,
    ST_CYC_END,
    ST_RESYNC,
    ST_EMIT
  } state_e;

  localparam int unsigned ResyncCycles = 5;

  // table and ring sizes, tied to the 4-bit slot and drop fields
  localparam int unsigned MaxTasks     = 16;
  localparam int unsigned PendingDepth = 8;

  // result item as it leaves the block
  typedef struct packed {
    logic        resynced;
    logic [3:0]  dropped_count;
    logic [31:0] late_ms;
    logic        overrun;
    logic [3:0]  task_slot;
    kind_e       kind;
    logic        last;
  } result_t;

  // request to the modulo unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

endpackage
`default_nettype wire

>>> rtl/core/ptrs_mod.sv
// ptrs_mod: bit-serial 32-bit unsigned remainder unit, one bit per cycle
// depends on ptrs_pkg
`timescale 1ns / 1ps
`default_nettype none
module ptrs_mod (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  ptrs_pkg::mod_req_t req_i,
  output logic             done_o,
  output logic [31:0]      rem_o
);
  logic [31:0] num_q, num_d, div_q, div_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] shifted, diff;

  always_comb begin
    num_d = num_q; div_d = div_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    shifted = {rem_q, num_q[31]};
    diff = shifted - {1'b0, div_q};
    if (req_i.start) begin
      num_d = req_i.dividend; div_d = req_i.divisor; rem_d = '0;
      cnt_d = 6'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step
      rem_d = (shifted >= {1'b0, div_q}) ? diff[31:0] : shifted[31:0];
      num_d = {num_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; div_q <= div_d; rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd31);
  assign rem_o  = rem_d;
endmodule
`default_nettype wire

>>> rtl/core/periodic_task_release_scheduler_top.sv
// periodic_task_release_scheduler_top: task table, pending ring and sequencer
// depends on ptrs_pkg and ptrs_mod
`timescale 1ns / 1ps
`default_nettype none
// usage:
//   s_axis carries one command transaction: op (add, start, stop, tick) with
//   period, phase and current time. m_axis returns the results of that
//   command, one transaction each, tlast on the final one. cfg_* writes the
//   base cycle length in milliseconds; write it only while the block is idle.
// sequencing:
//   one command at a time. add, stop, not-due and rejected commands answer
//   with one result in the cycle after acceptance. start walks the task
//   table, reading and rewriting each task. a due tick drains the pending
//   ring (read and write per entry), scans every task (read and check, and
//   for a released task the bit-serial modulo unit, then write-back and
//   dispatch), then gives the cycle-end result.
// the task table and the pending ring live in synchronous memories with a
// registered read port; entries are undefined until written and need no
// clearing pass. reset clears the control state: no tasks, stopped, ring
// empty, base 10. a stalled receiver holds the current result in the output
// register and the sequencer waits; no result is ever lost or repeated.
module periodic_task_release_scheduler_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // op[1:0], period[33:2], phase[65:34], now_ms[97:66], zero fill
  input  wire  [103:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // kind[2:0], task_slot[6:3], overrun[7], late_ms[39:8],
  // dropped_count[43:40], resynced[44], zero fill
  output logic [47:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [15:0]  cfg_data_i
);
  localparam int unsigned TW = $clog2(ptrs_pkg::MaxTasks);
  localparam int unsigned CW = $clog2(ptrs_pkg::MaxTasks + 1);
  localparam int unsigned PW = $clog2(ptrs_pkg::PendingDepth);
  localparam int unsigned RW = PW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(ptrs_pkg::MaxTasks);
  localparam logic [RW-1:0] Depth  = RW'(ptrs_pkg::PendingDepth);

  // memories
  logic [95:0] tbl_mem [ptrs_pkg::MaxTasks];      // {period, phase, last}
  logic [63:0] ring_mem [ptrs_pkg::PendingDepth]; // {period, phase}

  // control registers
  ptrs_pkg::state_e state_q, state_d;
  logic [15:0]   base_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic [31:0]   start_q, start_d, due_q, due_d;
  logic [RW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [3:0]    drop_q, drop_d;
  logic          ovr_q, ovr_d;
  logic [31:0]   late_q, late_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   d_q, d_d;
  ptrs_pkg::state_e ret_q, ret_d;

  // output register
  logic               ovalid_q, ovalid_d;
  ptrs_pkg::result_t  res_q, res_d;

  // memory ports
  logic          tbl_we;  logic [TW-1:0] tbl_wa; logic [95:0] tbl_wd;
  logic [TW-1:0] tbl_ra;  logic [95:0] tbl_rd;
  logic          ring_we; logic [PW-1:0] ring_wa; logic [63:0] ring_wd;
  logic [PW-1:0] ring_ra; logic [63:0] ring_rd;

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd <= tbl_mem[tbl_ra];
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_rd <= ring_mem[ring_ra];
  end

  // input fields
  logic [1:0]  in_op;
  logic [31:0] in_per, in_ph, in_now;
  assign in_op  = s_axis_tdata_i[1:0];
  assign in_per = s_axis_tdata_i[33:2];
  assign in_ph  = s_axis_tdata_i[65:34];
  assign in_now = s_axis_tdata_i[97:66];

  logic in_acc, out_free;
  assign out_free        = !ovalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ptrs_pkg::ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // modulo unit
  ptrs_pkg::mod_req_t mreq;
  logic        mdone;
  logic [31:0] mrem;
  ptrs_mod u_mod (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(mreq), .done_o(mdone),
                  .rem_o(mrem));

  logic [RW-1:0] ring_cnt;
  assign ring_cnt = tail_q - head_q;

  logic [31:0] base32, lag, due_nx;
  assign base32 = {16'd0, base_q};
  assign due_nx = due_q + base32;
  assign lag    = now_q - due_q;

  logic [31:0] rd_per, rd_ph, rd_last, late_in;
  assign rd_per  = tbl_rd[95:64];
  assign rd_ph   = tbl_rd[63:32];
  assign rd_last = tbl_rd[31:0];
  assign late_in = in_now - due_q;

  // task release test and resync test
  logic scan_due, do_resync;
  assign scan_due  = (rd_per != '0) && ((now_q - start_q) >= rd_ph) &&
                     ((now_q - rd_last) >= rd_per);
  assign do_resync = (lag != '0) && !lag[31] &&
                     ({3'd0, lag} > 35'(ptrs_pkg::ResyncCycles) * {19'd0, base_q});

  function automatic ptrs_pkg::result_t mk(ptrs_pkg::kind_e k, logic lst);
    ptrs_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.last = lst;
    return r;
  endfunction

  // next state
  always_comb begin
    state_d = state_q; ret_d = ret_q;
    unique case (state_q)
      ptrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == ptrs_pkg::OP_START && !run_q) begin
            state_d = ptrs_pkg::ST_SEED_RD;
          end else if (in_op == ptrs_pkg::OP_TICK && run_q && !late_in[31]) begin
            state_d = ptrs_pkg::ST_DRAIN_RD;
          end
        end
      end
      ptrs_pkg::ST_SEED_RD: begin
        if (idx_q >= cnt_q) begin
          state_d = ptrs_pkg::ST_EMIT;
          ret_d = ptrs_pkg::ST_IDLE;
        end else begin
          state_d = ptrs_pkg::ST_SEED_WR;
        end
      end
      ptrs_pkg::ST_SEED_WR: state_d = ptrs_pkg::ST_SEED_RD;
      ptrs_pkg::ST_DRAIN_RD: begin
        if (ring_cnt == '0) state_d = ptrs_pkg::ST_SCAN_RD;
        else state_d = ptrs_pkg::ST_DRAIN_WR;
      end
      ptrs_pkg::ST_DRAIN_WR: state_d = ptrs_pkg::ST_DRAIN_RD;
      ptrs_pkg::ST_SCAN_RD: begin
        if (idx_q >= cnt_q) state_d = ptrs_pkg::ST_CYC_END;
        else state_d = ptrs_pkg::ST_SCAN_CHK;
      end
      ptrs_pkg::ST_SCAN_CHK: begin
        if (scan_due) state_d = ptrs_pkg::ST_SCAN_MOD;
        else state_d = ptrs_pkg::ST_SCAN_RD;
      end
      ptrs_pkg::ST_SCAN_MOD: begin
        if (mdone) state_d = ptrs_pkg::ST_SCAN_WR;
      end
      // wait until the output register is free before loading a result
      ptrs_pkg::ST_SCAN_WR: begin
        if (out_free) begin
          ret_d = ptrs_pkg::ST_SCAN_RD;
          state_d = ptrs_pkg::ST_EMIT;
        end
      end
      ptrs_pkg::ST_CYC_END: state_d = ptrs_pkg::ST_RESYNC;
      ptrs_pkg::ST_RESYNC: begin
        if (out_free) begin
          ret_d = ptrs_pkg::ST_IDLE;
          state_d = ptrs_pkg::ST_EMIT;
        end
      end
      ptrs_pkg::ST_EMIT: begin
        if (out_free) state_d = ret_q;
      end
      default: state_d = ptrs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q; run_d = run_q; start_d = start_q;
    due_d = due_q; head_d = head_q; tail_d = tail_q; idx_d = idx_q;
    drop_d = drop_q; ovr_d = ovr_q; late_d = late_q; now_d = now_q;
    d_d = d_q;
    ovalid_d = ovalid_q && !m_axis_tready_i; res_d = res_q;
    tbl_we = 1'b0; tbl_wa = idx_q[TW-1:0]; tbl_wd = '0; tbl_ra = idx_q[TW-1:0];
    ring_we = 1'b0; ring_wa = tail_q[PW-1:0]; ring_wd = {in_per, in_ph};
    ring_ra = head_q[PW-1:0];
    mreq = '0;
    unique case (state_q)
      ptrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          ovalid_d = 1'b1;
          res_d = mk(ptrs_pkg::KIND_REJECTED, 1'b1);
          now_d = in_now;
          unique case (ptrs_pkg::op_e'(in_op))
            ptrs_pkg::OP_ADD: begin
              if (in_per == '0) begin
              end else if (!run_q) begin
                if (cnt_q < MaxCnt) begin
                  tbl_we = 1'b1; tbl_wa = cnt_q[TW-1:0];
                  tbl_wd = {in_per, in_ph, 32'd0};
                  cnt_d = cnt_q + 1'b1;
                  res_d.kind = ptrs_pkg::KIND_ADDED;
                end
              end else if (ring_cnt < Depth) begin
                ring_we = 1'b1;
                tail_d = tail_q + 1'b1;
                res_d.kind = ptrs_pkg::KIND_QUEUED;
              end
            end
            ptrs_pkg::OP_START: begin
              if (!run_q) begin
                run_d = 1'b1; start_d = in_now; due_d = in_now + base32;
                idx_d = '0; ovalid_d = 1'b0;
              end
            end
            ptrs_pkg::OP_STOP: begin
              run_d = 1'b0;
              res_d.kind = ptrs_pkg::KIND_STOPPED;
            end
            default: begin
              if (!run_q) begin
              end else if (late_in[31]) begin
                res_d.kind = ptrs_pkg::KIND_NOT_DUE;
              end else begin
                ovalid_d = 1'b0;
                late_d = late_in; ovr_d = late_in > base32; drop_d = '0;
              end
            end
          endcase
        end
      end
      // start: last = now + phase - period per task
      ptrs_pkg::ST_SEED_RD: begin
        if (idx_q >= cnt_q) begin
          res_d = mk(ptrs_pkg::KIND_STARTED, 1'b1);
        end
      end
      ptrs_pkg::ST_SEED_WR: begin
        tbl_we = 1'b1;
        tbl_wd = {rd_per, rd_ph, now_q + rd_ph - rd_per};
        idx_d = idx_q + 1'b1;
      end
      // tick: move pending adds into the table, counting those that do not fit as dropped
      ptrs_pkg::ST_DRAIN_RD: begin
        if (ring_cnt == '0) idx_d = '0;
      end
      ptrs_pkg::ST_DRAIN_WR: begin
        if (cnt_q < MaxCnt) begin
          tbl_we = 1'b1; tbl_wa = cnt_q[TW-1:0];
          tbl_wd = {ring_rd, 32'd0};
          cnt_d = cnt_q + 1'b1;
        end else begin
          drop_d = drop_q + 1'b1;
        end
        head_d = head_q + 1'b1;
      end
      // tick: release due tasks
      ptrs_pkg::ST_SCAN_RD: begin
      end
      ptrs_pkg::ST_SCAN_CHK: begin
        d_d = now_q - rd_last;
        if (scan_due) begin
          mreq.start = 1'b1; mreq.dividend = now_q - rd_last; mreq.divisor = rd_per;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ptrs_pkg::ST_SCAN_MOD: begin
        if (mdone) d_d = mrem;
      end
      ptrs_pkg::ST_SCAN_WR: begin
        if (out_free) begin
          tbl_we = 1'b1;
          tbl_wd = {rd_per, rd_ph, now_q - d_q};
          res_d = mk(ptrs_pkg::KIND_DISPATCH, 1'b0);
          res_d.task_slot = 4'(idx_q);
          idx_d = idx_q + 1'b1;
        end
      end
      ptrs_pkg::ST_CYC_END: begin
        due_d = due_nx;
      end
      ptrs_pkg::ST_RESYNC: begin
        if (out_free) begin
          res_d = mk(ptrs_pkg::KIND_CYC_END, 1'b1);
          res_d.overrun = ovr_q; res_d.late_ms = late_q; res_d.dropped_count = drop_q;
          if (do_resync) begin
            due_d = now_q + base32;
            res_d.resynced = 1'b1;
          end
        end
      end
      ptrs_pkg::ST_EMIT: begin
        if (out_free) ovalid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptrs_pkg::ST_IDLE; ret_q <= ptrs_pkg::ST_IDLE;
      base_q <= 16'd10; cnt_q <= '0; run_q <= 1'b0; start_q <= '0; due_q <= '0;
      head_q <= '0; tail_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      if (cfg_valid_i) base_q <= cfg_data_i;
      cnt_q <= cnt_d; run_q <= run_d; start_q <= start_d; due_q <= due_d;
      head_q <= head_d; tail_q <= tail_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; drop_q <= drop_d; ovr_q <= ovr_d; late_q <= late_d;
    now_q <= now_d; d_q <= d_d; res_q <= res_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tdata_o  = {3'd0, res_q.resynced, res_q.dropped_count, res_q.late_ms,
                            res_q.overrun, res_q.task_slot, res_q.kind};
endmodule
`default_nettype wire

>>> verif/tb_periodic_task_release_scheduler_top.sv
// tb_periodic_task_release_scheduler_top: self-checking testbench for the periodic task
// release scheduler; commands go in on s_axis, results are predicted and checked off m_axis
// depends on ptrs_pkg and periodic_task_release_scheduler_top
`timescale 1ns / 1ps

// scheduler predictor plus the queue of results it expects
class sched_scoreboard;
  ptrs_pkg::result_t expected_q[$];
  int          fails;
  int          n_checked;
  int          n_dispatch;
  int          n_cyc_end;
  int          n_resync;
  int          n_dropped;
  logic [15:0] base_ms;
  logic [31:0] tsk_period[16];
  logic [31:0] tsk_phase[16];
  logic [31:0] tsk_release[16];
  int          n_tasks;
  bit          running;
  logic [31:0] run_start;
  logic [31:0] due_ms;
  logic [31:0] ring_period[8];
  logic [31:0] ring_phase[8];
  int          ring_head;
  int          ring_tail;

  function new();
    base_ms = 16'd10;
    n_tasks = 0;
    running = 0;
    run_start = '0;
    due_ms = '0;
    ring_head = 0;
    ring_tail = 0;
  endfunction

  function int ring_fill();
    return (ring_tail + 16 - ring_head) % 16;
  endfunction

  function void push(ptrs_pkg::kind_e k, logic [3:0] slot, logic ovr, logic [31:0] late,
                     logic [3:0] drop, logic rs, logic lst);
    ptrs_pkg::result_t r;
    r.kind = k;
    r.task_slot = slot;
    r.overrun = ovr;
    r.late_ms = late;
    r.dropped_count = drop;
    r.resynced = rs;
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  function bit table_put(logic [31:0] per, logic [31:0] ph);
    if (n_tasks >= 16) return 0;
    tsk_period[n_tasks] = per;
    tsk_phase[n_tasks] = ph;
    tsk_release[n_tasks] = '0;
    n_tasks++;
    return 1;
  endfunction

  // predict the results of one accepted command
  function void note_command(ptrs_pkg::op_e op, logic [31:0] per, logic [31:0] ph,
                             logic [31:0] now);
    logic [31:0] late;
    logic [31:0] lag;
    logic [31:0] d;
    int          drop;
    logic        ovr;
    logic        rs;
    case (op)
      ptrs_pkg::OP_ADD: begin
        if (per == 0) push(ptrs_pkg::KIND_REJECTED, 0, 0, 0, 0, 0, 1);
        else if (!running)
          push(table_put(per, ph) ? ptrs_pkg::KIND_ADDED : ptrs_pkg::KIND_REJECTED,
               0, 0, 0, 0, 0, 1);
        else if (ring_fill() >= 8) push(ptrs_pkg::KIND_REJECTED, 0, 0, 0, 0, 0, 1);
        else begin
          ring_period[ring_tail % 8] = per;
          ring_phase[ring_tail % 8] = ph;
          ring_tail = (ring_tail + 1) % 16;
          push(ptrs_pkg::KIND_QUEUED, 0, 0, 0, 0, 0, 1);
        end
      end
      ptrs_pkg::OP_START: begin
        if (running) push(ptrs_pkg::KIND_REJECTED, 0, 0, 0, 0, 0, 1);
        else begin
          running = 1;
          run_start = now;
          due_ms = now + 32'(base_ms);
          for (int i = 0; i < n_tasks; i++) tsk_release[i] = now + tsk_phase[i] - tsk_period[i];
          push(ptrs_pkg::KIND_STARTED, 0, 0, 0, 0, 0, 1);
        end
      end
      ptrs_pkg::OP_STOP: begin
        running = 0;
        push(ptrs_pkg::KIND_STOPPED, 0, 0, 0, 0, 0, 1);
      end
      default: begin
        late = now - due_ms;
        if (!running) push(ptrs_pkg::KIND_REJECTED, 0, 0, 0, 0, 0, 1);
        else if (late[31]) push(ptrs_pkg::KIND_NOT_DUE, 0, 0, 0, 0, 0, 1);
        else begin
          ovr = late > 32'(base_ms);
          drop = 0;
          // pending adds land in the table first, overflow is dropped
          while (ring_fill() != 0) begin
            if (!table_put(ring_period[ring_head % 8], ring_phase[ring_head % 8])) drop++;
            ring_head = (ring_head + 1) % 16;
          end
          for (int i = 0; i < n_tasks; i++) begin
            d = now - tsk_release[i];
            if ((now - run_start) >= tsk_phase[i] && d >= tsk_period[i]) begin
              tsk_release[i] = now - (d % tsk_period[i]);
              push(ptrs_pkg::KIND_DISPATCH, 4'(i), 0, 0, 0, 0, 0);
              n_dispatch++;
            end
          end
          due_ms = due_ms + 32'(base_ms);
          lag = now - due_ms;
          rs = (lag != 0) && !lag[31] && (lag > 32'(base_ms) * 5);
          if (rs) begin
            due_ms = now + 32'(base_ms);
            n_resync++;
          end
          n_dropped += drop;
          n_cyc_end++;
          push(ptrs_pkg::KIND_CYC_END, 0, ovr, late, 4'(drop), rs, 1);
        end
      end
    endcase
  endfunction

  // compare one result transaction with the oldest expectation
  function void check_result(logic [47:0] data, logic lst);
    ptrs_pkg::result_t got;
    ptrs_pkg::result_t exp_r;
    got.kind = ptrs_pkg::kind_e'(data[2:0]);
    got.task_slot = data[6:3];
    got.overrun = data[7];
    got.late_ms = data[39:8];
    got.dropped_count = data[43:40];
    got.resynced = data[44];
    got.last = lst;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result kind=%0d slot=%0d", $time, got.kind, got.task_slot);
      fails++;
      return;
    end
    exp_r = expected_q.pop_front();
    n_checked++;
    if (got !== exp_r || data[47:45] !== 3'b0) begin
      $display("%0t: mismatch expected kind=%0d slot=%0d ovr=%0d late=%0d drop=%0d rs=%0d last=%0d",
               $time, exp_r.kind, exp_r.task_slot, exp_r.overrun, exp_r.late_ms,
               exp_r.dropped_count, exp_r.resynced, exp_r.last);
      $display("%0t:          actual kind=%0d slot=%0d ovr=%0d late=%0d drop=%0d rs=%0d last=%0d",
               $time, got.kind, got.task_slot, got.overrun, got.late_ms,
               got.dropped_count, got.resynced, got.last);
      fails++;
    end
  endfunction
endclass

module tb_periodic_task_release_scheduler_top;

  localparam int CycleLimit = 2000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [47:0]  m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  sched_scoreboard sb;
  int              cycles = 0;
  int              burst_left = 0;
  int              n_cmds = 0;
  int              stall_mode = 0;

  periodic_task_release_scheduler_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check each accepted transaction, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
    if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;                        // no backpressure
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0); // heavy stalls
      default: m_axis_tready_i <= ((cycles % 7) < 4);
    endcase
  end

  // send one command, with bursts and random gaps in between
  task automatic send_cmd(ptrs_pkg::op_e op, logic [31:0] per, logic [31:0] ph,
                          logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'b0, now, ph, per, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(op, per, ph, now);
    n_cmds++;
  endtask

  // idle the input, let all results drain, then write the base cycle
  task automatic write_base(logic [15:0] value);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.base_ms = value;
  endtask

  function automatic logic [31:0] pick_period();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel <= 2) return $urandom;
    return $urandom_range(1, 40);
  endfunction

  function automatic logic [31:0] pick_phase();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 60);
  endfunction

  // tick time near the due time, sometimes early, far late or anywhere
  function automatic logic [31:0] pick_tick_time();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return sb.due_ms - $urandom_range(1, 50);
    if (sel == 1) return sb.due_ms + 32'(sb.base_ms) * 7 + $urandom_range(1, 100);
    if (sel == 2) return $urandom;
    return sb.due_ms + $urandom_range(0, 2 * sb.base_ms + 3);
  endfunction

  task automatic random_phase(int n_items);
    int sel;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 4 && sb.running) begin
        // flood the pending ring past its depth
        repeat (9) send_cmd(ptrs_pkg::OP_ADD, $urandom_range(1, 30), pick_phase(), $urandom);
      end else if (sel < 35) send_cmd(ptrs_pkg::OP_ADD, pick_period(), pick_phase(), $urandom);
      else if (sel < 45) send_cmd(ptrs_pkg::OP_START, $urandom, $urandom, $urandom);
      else if (sel < 52) send_cmd(ptrs_pkg::OP_STOP, $urandom, $urandom, $urandom);
      else send_cmd(ptrs_pkg::OP_TICK, $urandom, $urandom, pick_tick_time());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: stopped-side cases, wrapping start, early and late ticks
    write_base(16'd1);
    send_cmd(ptrs_pkg::OP_ADD, 32'd0, 32'd5, 32'd0);
    send_cmd(ptrs_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(ptrs_pkg::OP_ADD, 32'd3, 32'd0, 32'd0);
    send_cmd(ptrs_pkg::OP_ADD, 32'd1, 32'd2, 32'd0);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'd100);
    send_cmd(ptrs_pkg::OP_STOP, '0, '0, '0);
    send_cmd(ptrs_pkg::OP_START, '0, '0, 32'hFFFF_FFF0);
    send_cmd(ptrs_pkg::OP_START, '0, '0, 32'd5);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'hFFFF_FFF0);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'hFFFF_FFF1);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'hFFFF_FFF4);
    send_cmd(ptrs_pkg::OP_ADD, 32'd2, 32'd0, '0);
    send_cmd(ptrs_pkg::OP_ADD, 32'd5, 32'd1, '0);
    send_cmd(ptrs_pkg::OP_STOP, '0, '0, '0);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'd3);
    send_cmd(ptrs_pkg::OP_START, '0, '0, 32'd1000);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'd5000);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'd5003);
    send_cmd(ptrs_pkg::OP_TICK, '0, '0, 32'd9000);

    write_base(16'd0);
    random_phase(20);
    write_base(16'hFFFF);
    random_phase(20);
    write_base(16'd10);
    random_phase(20);
    write_base($urandom_range(1, 100));
    random_phase(20);

    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d commands, %0d results checked: %0d dispatches, %0d cycle ends",
             n_cmds, sb.n_checked, sb.n_dispatch, sb.n_cyc_end);
    $display("%0d resyncs, %0d dropped adds, %0d tasks in table, %0d failures",
             sb.n_resync, sb.n_dropped, sb.n_tasks, sb.fails);
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ptrs_pkg.sv
rtl/core/ptrs_mod.sv
rtl/core/periodic_task_release_scheduler_top.sv
verif/tb_periodic_task_release_scheduler_top.sv
